// ===== rtl/hae_pkg.sv =====
// ----------------------------------------------------------------------------
// hae_pkg
// Types, widths and constants shared by the Hall angle and speed estimator.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package hae_pkg;

    localparam int ANGLE_W   = 32;
    localparam int SPEED_W   = 26;
    localparam int HALL_W    = 3;
    localparam int INTV_W    = 16;
    localparam int CMD_W     = 2;
    localparam int PP_W      = 6;
    localparam int TO_W      = 10;
    localparam int LR_W      = 16;
    localparam int CFG_W     = 16;
    localparam int CFG_IDX_W = 2;
    localparam int MS_W      = 16;
    localparam int SUM_W     = 20;
    localparam int PROD_LR_W = SUM_W + LR_W;
    localparam int PROD_PP_W = SUM_W + PP_W;
    localparam int DIV_NUM_W = 64;
    localparam int DIV_DEN_W = 40;

    typedef enum logic [CMD_W-1:0] {
        CMD_CTRL_TICK = 2'd0,
        CMD_HALL_EDGE = 2'd1,
        CMD_MS_TICK   = 2'd2,
        CMD_NONE      = 2'd3
    } t_cmd_code;

    localparam logic [CFG_IDX_W-1:0] CFG_PAIR_COUNT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT_MS = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_LOOP_RATE  = 2'd2;

    localparam logic [PP_W-1:0] PP_RESET = 6'd4;
    localparam logic [TO_W-1:0] TO_RESET = 10'd50;
    localparam logic [LR_W-1:0] LR_RESET = 16'd10000;

    localparam logic [HALL_W-1:0] HALL_ALL_LOW  = 3'd0;
    localparam logic [HALL_W-1:0] HALL_ALL_HIGH = 3'd7;

    localparam logic [ANGLE_W-1:0] SECTOR_ANGLE [0:7] = '{
        32'd0, 32'd3982996097, 32'd2505562719, 32'd3227099362,
        32'd1079642136, 32'd378833926, 32'd1829788037, 32'd0
    };

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_EXEC,
        ST_SUM,
        ST_MUL,
        ST_DIV_STEP_GO,
        ST_DIV_STEP_WAIT,
        ST_DIV_SPEED_GO,
        ST_DIV_SPEED_WAIT,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic load;
        logic exec;
        logic sum_step;
        logic mul;
        logic zero_speed;
        logic div_start;
        logic div_speed;
        logic store_step;
        logic store_speed;
        logic out_load;
    } t_dp_cmd;

    typedef struct packed {
        logic need_calc;
        logic sum_last;
        logic sum_zero;
        logic div_done;
        logic out_free;
    } t_dp_stat;

endpackage

`default_nettype wire

// ===== rtl/hae_div.sv =====
// ----------------------------------------------------------------------------
// hae_div
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module hae_div (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_start,
    input  wire logic [hae_pkg::DIV_NUM_W-1:0]   i_dividend,
    input  wire logic [hae_pkg::DIV_DEN_W-1:0]   i_divisor,
    output logic                                 o_done,
    output logic      [hae_pkg::DIV_NUM_W-1:0]   o_quotient
);
    import hae_pkg::*;

    localparam int CNT_W = $clog2(DIV_NUM_W);

    logic [DIV_NUM_W-1:0] r_quo;
    logic [DIV_DEN_W-1:0] r_rem;
    logic [DIV_DEN_W-1:0] r_den;
    logic [CNT_W-1:0]     r_cnt;
    logic                 r_busy;
    logic                 r_done;

    logic [DIV_DEN_W:0]   n_trial;
    logic                 n_fits;

    assign n_trial = {r_rem, r_quo[DIV_NUM_W-1]};
    assign n_fits  = n_trial >= {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CNT_W'(DIV_NUM_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= i_dividend;
            r_rem <= '0;
            r_den <= i_divisor;
        end else if (r_busy) begin
            if (n_fits) begin
                r_rem <= DIV_DEN_W'(n_trial - {1'b0, r_den});
            end else begin
                r_rem <= n_trial[DIV_DEN_W-1:0];
            end
            r_quo <= {r_quo[DIV_NUM_W-2:0], n_fits};
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_quo;

endmodule

`default_nettype wire

// ===== rtl/hae_datapath.sv =====
// ----------------------------------------------------------------------------
// hae_datapath
// Estimator state, interval ring, ring summation, products, divider and
// output register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module hae_datapath #(
    parameter int EDGES_PER_UPDATE = 6,
    parameter int CAPTURE_CLOCK_HZ = 1000000
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire hae_pkg::t_dp_cmd                  i_cmd,
    output hae_pkg::t_dp_stat                      o_stat,
    input  wire logic                              i_cfg_we,
    input  wire logic [hae_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  wire logic [hae_pkg::CFG_W-1:0]         i_cfg_data,
    input  wire logic [hae_pkg::CMD_W-1:0]         i_command,
    input  wire logic [hae_pkg::HALL_W-1:0]        i_hall_state,
    input  wire logic [hae_pkg::INTV_W-1:0]        i_edge_interval,
    input  wire logic                              i_out_ready,
    output logic                                   o_out_valid,
    output logic      [hae_pkg::ANGLE_W-1:0]       o_angle,
    output logic      [hae_pkg::ANGLE_W-1:0]       o_angle_step,
    output logic      [hae_pkg::SPEED_W-1:0]       o_speed_rpm
);
    import hae_pkg::*;

    localparam int IDX_W = (EDGES_PER_UPDATE > 1) ? $clog2(EDGES_PER_UPDATE) : 1;
    localparam logic [DIV_NUM_W-1:0] StepNum =
        (64'(CAPTURE_CLOCK_HZ) * 64'(EDGES_PER_UPDATE)) << 32;
    localparam logic [DIV_NUM_W-1:0] SpeedNum =
        64'(10) * 64'(CAPTURE_CLOCK_HZ) * 64'(EDGES_PER_UPDATE);

    // configuration
    logic [PP_W-1:0] r_pair_count;
    logic [TO_W-1:0] r_timeout;
    logic [LR_W-1:0] r_loop_rate;

    // latched beat
    t_cmd_code         r_cmd;
    logic [HALL_W-1:0] r_hall;
    logic [INTV_W-1:0] r_intv;

    // estimator state
    logic [ANGLE_W-1:0] r_angle;
    logic [ANGLE_W-1:0] r_step;
    logic [SPEED_W-1:0] r_speed;
    logic [INTV_W-1:0]  r_ring [0:EDGES_PER_UPDATE-1];
    logic [IDX_W-1:0]   r_ring_idx;
    logic               r_pending;
    logic [MS_W-1:0]    r_ms;

    // speed update
    logic [SUM_W-1:0]     r_sum;
    logic [IDX_W-1:0]     r_sum_idx;
    logic [PROD_LR_W-1:0] r_prod_lr;
    logic [PROD_PP_W-1:0] r_prod_pp;

    logic                 r_out_valid;

    logic [MS_W-1:0]      n_ms;
    logic                 n_timeout;
    logic                 n_snap;
    logic [PP_W-1:0]      n_pp;
    logic [LR_W-1:0]      n_lr;
    logic [DIV_NUM_W-1:0] n_dividend;
    logic [DIV_DEN_W-1:0] n_divisor;
    logic                 div_done;
    logic [DIV_NUM_W-1:0] div_quo;

    assign n_ms      = (r_ms == '1) ? r_ms : r_ms + 1'b1;
    assign n_timeout = n_ms > MS_W'(r_timeout);
    assign n_snap    = (r_hall != HALL_ALL_LOW) && (r_hall != HALL_ALL_HIGH);
    assign n_pp      = (r_pair_count == '0) ? PP_W'(1) : r_pair_count;
    assign n_lr      = (r_loop_rate == '0) ? LR_W'(1) : r_loop_rate;

    always_comb begin
        if (i_cmd.div_speed) begin
            n_dividend = SpeedNum;
            n_divisor  = DIV_DEN_W'(r_prod_pp);
        end else begin
            n_dividend = StepNum;
            n_divisor  = DIV_DEN_W'({r_prod_lr, 2'b00}) + DIV_DEN_W'({r_prod_lr, 1'b0});
        end
    end

    hae_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.div_start),
        .i_dividend (n_dividend),
        .i_divisor  (n_divisor),
        .o_done     (div_done),
        .o_quotient (div_quo)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pair_count <= PP_RESET;
            r_timeout    <= TO_RESET;
            r_loop_rate  <= LR_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_PAIR_COUNT: r_pair_count <= i_cfg_data[PP_W-1:0];
                CFG_TIMEOUT_MS: r_timeout    <= i_cfg_data[TO_W-1:0];
                CFG_LOOP_RATE:  r_loop_rate  <= i_cfg_data[LR_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_cmd  <= t_cmd_code'(i_command);
            r_hall <= i_hall_state;
            r_intv <= i_edge_interval;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_angle    <= '0;
            r_step     <= '0;
            r_speed    <= '0;
            r_ring_idx <= '0;
            r_pending  <= 1'b0;
            r_ms       <= '0;
            for (int i = 0; i < EDGES_PER_UPDATE; i++) begin
                r_ring[i] <= '0;
            end
        end else begin
            if (i_cmd.exec) begin
                case (r_cmd)
                    CMD_CTRL_TICK: r_angle <= r_angle + r_step;
                    CMD_HALL_EDGE: begin
                        if (n_snap) begin
                            r_angle <= SECTOR_ANGLE[r_hall];
                        end
                        r_ms               <= '0;
                        r_ring[r_ring_idx] <= r_intv;
                        if (r_ring_idx == IDX_W'(EDGES_PER_UPDATE - 1)) begin
                            r_ring_idx <= '0;
                            r_pending  <= 1'b1;
                        end else begin
                            r_ring_idx <= r_ring_idx + 1'b1;
                        end
                    end
                    CMD_MS_TICK: begin
                        r_ms      <= n_ms;
                        r_pending <= 1'b0;
                        if (n_timeout) begin
                            r_speed <= '0;
                            r_step  <= '0;
                            if (n_snap) begin
                                r_angle <= SECTOR_ANGLE[r_hall];
                            end
                        end
                    end
                    default: ;
                endcase
            end
            if (i_cmd.zero_speed) begin
                r_speed <= '0;
                r_step  <= '0;
            end
            if (i_cmd.store_step) begin
                r_step <= (|div_quo[DIV_NUM_W-1:ANGLE_W]) ? '1 : div_quo[ANGLE_W-1:0];
            end
            if (i_cmd.store_speed) begin
                r_speed <= (|div_quo[DIV_NUM_W-1:SPEED_W]) ? '1 : div_quo[SPEED_W-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.exec) begin
            r_sum     <= '0;
            r_sum_idx <= '0;
        end else if (i_cmd.sum_step) begin
            r_sum     <= r_sum + SUM_W'(r_ring[r_sum_idx]);
            r_sum_idx <= r_sum_idx + 1'b1;
        end
        if (i_cmd.mul) begin
            r_prod_lr <= PROD_LR_W'(r_sum) * PROD_LR_W'(n_lr);
            r_prod_pp <= PROD_PP_W'(r_sum) * PROD_PP_W'(n_pp);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            o_angle      <= r_angle;
            o_angle_step <= r_step;
            o_speed_rpm  <= r_speed;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_stat.need_calc = (r_cmd == CMD_MS_TICK) && !n_timeout && r_pending;
    assign o_stat.sum_last  = r_sum_idx == IDX_W'(EDGES_PER_UPDATE - 1);
    assign o_stat.sum_zero  = r_sum == '0;
    assign o_stat.div_done  = div_done;
    assign o_stat.out_free  = !r_out_valid || i_out_ready;

endmodule

`default_nettype wire

// ===== rtl/hae_ctrl.sv =====
// ----------------------------------------------------------------------------
// hae_ctrl
// Sequencer for one beat: update, then ring sum, products and two divisions when a speed update is due, output.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module hae_ctrl (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_in_valid,
    output logic                   o_in_ready,
    input  wire hae_pkg::t_dp_stat i_stat,
    output hae_pkg::t_dp_cmd       o_cmd
);
    import hae_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = ST_EXEC;
                end
            end
            ST_EXEC: begin
                o_cmd.exec = 1'b1;
                n_state    = i_stat.need_calc ? ST_SUM : ST_DONE;
            end
            ST_SUM: begin
                o_cmd.sum_step = 1'b1;
                if (i_stat.sum_last) begin
                    n_state = ST_MUL;
                end
            end
            ST_MUL: begin
                if (i_stat.sum_zero) begin
                    o_cmd.zero_speed = 1'b1;
                    n_state          = ST_DONE;
                end else begin
                    o_cmd.mul = 1'b1;
                    n_state   = ST_DIV_STEP_GO;
                end
            end
            ST_DIV_STEP_GO: begin
                o_cmd.div_start = 1'b1;
                n_state         = ST_DIV_STEP_WAIT;
            end
            ST_DIV_STEP_WAIT: begin
                if (i_stat.div_done) begin
                    o_cmd.store_step = 1'b1;
                    n_state          = ST_DIV_SPEED_GO;
                end
            end
            ST_DIV_SPEED_GO: begin
                o_cmd.div_start = 1'b1;
                o_cmd.div_speed = 1'b1;
                n_state         = ST_DIV_SPEED_WAIT;
            end
            ST_DIV_SPEED_WAIT: begin
                if (i_stat.div_done) begin
                    o_cmd.store_speed = 1'b1;
                    n_state           = ST_DONE;
                end
            end
            ST_DONE: begin
                if (i_stat.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

endmodule

`default_nettype wire

// ===== rtl/hall_angle_speed_estimator.sv =====
// Each beat is latched and executed. For a millisecond tick with a speed update due,
// the ring is summed an entry a cycle, the products are formed and the divider is run
// twice, for the angle step and then the speed, each with start and store; when the
// ring sum is zero, speed and step are cleared instead. The result then waits for a
// free output. One beat in work at a time; the next is taken once the result is loaded.
// Synchronous active-low reset clears estimator state and restores register defaults.
// ----------------------------------------------------------------------------
// hall_angle_speed_estimator
// Hall sensor angle interpolation and speed estimation, top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module hall_angle_speed_estimator #(
    parameter int EDGES_PER_UPDATE = 6,
    parameter int CAPTURE_CLOCK_HZ = 1000000
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_cfg_we,
    input  wire logic [hae_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  wire logic [hae_pkg::CFG_W-1:0]         i_cfg_data,
    input  wire logic                              i_in_valid,
    output logic                                   o_in_ready,
    input  wire logic [hae_pkg::CMD_W-1:0]         i_command,
    input  wire logic [hae_pkg::HALL_W-1:0]        i_hall_state,
    input  wire logic [hae_pkg::INTV_W-1:0]        i_edge_interval,
    output logic                                   o_out_valid,
    input  wire logic                              i_out_ready,
    output logic      [hae_pkg::ANGLE_W-1:0]       o_angle,
    output logic      [hae_pkg::ANGLE_W-1:0]       o_angle_step,
    output logic      [hae_pkg::SPEED_W-1:0]       o_speed_rpm
);
    import hae_pkg::*;

    t_dp_cmd  dp_cmd;
    t_dp_stat dp_stat;

    hae_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_stat     (dp_stat),
        .o_cmd      (dp_cmd)
    );

    hae_datapath #(
        .EDGES_PER_UPDATE (EDGES_PER_UPDATE),
        .CAPTURE_CLOCK_HZ (CAPTURE_CLOCK_HZ)
    ) u_datapath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (dp_cmd),
        .o_stat          (dp_stat),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_command       (i_command),
        .i_hall_state    (i_hall_state),
        .i_edge_interval (i_edge_interval),
        .i_out_ready     (i_out_ready),
        .o_out_valid     (o_out_valid),
        .o_angle         (o_angle),
        .o_angle_step    (o_angle_step),
        .o_speed_rpm     (o_speed_rpm)
    );

endmodule

`default_nettype wire

// ===== rtl/hae_chk.sv =====
// ----------------------------------------------------------------------------
// hae_chk
// Port-level checks for the Hall angle and speed estimator.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module hae_chk (
    input wire logic                          i_clk,
    input wire logic                          i_rst_n,
    input wire logic                          i_in_valid,
    input wire logic                          o_in_ready,
    input wire logic                          o_out_valid,
    input wire logic                          i_out_ready,
    input wire logic [hae_pkg::ANGLE_W-1:0]   o_angle,
    input wire logic [hae_pkg::ANGLE_W-1:0]   o_angle_step,
    input wire logic [hae_pkg::SPEED_W-1:0]   o_speed_rpm
);
    import hae_pkg::*;

    // one beat in work at a time
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> !o_in_ready)
        else $error("input accepted while a beat is in work");

    // a result never appears in the cycle right after an accept
    a_no_instant_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready && !o_out_valid |=> !o_out_valid)
        else $error("result shown without processing time");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid)
        else $error("result beat dropped while stalled");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=>
            $stable(o_angle) && $stable(o_angle_step) && $stable(o_speed_rpm))
        else $error("result payload changed while stalled");

endmodule

bind hall_angle_speed_estimator hae_chk u_hae_chk (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_in_valid   (i_in_valid),
    .o_in_ready   (o_in_ready),
    .o_out_valid  (o_out_valid),
    .i_out_ready  (i_out_ready),
    .o_angle      (o_angle),
    .o_angle_step (o_angle_step),
    .o_speed_rpm  (o_speed_rpm)
);

`default_nettype wire
